// ----- design/itp_pkg.sv -----
// Shared types, character codes and classification helpers for the
// infix-to-postfix converter. No dependencies.
package itp_pkg;

  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Precedence codes, ordered so an unsigned compare matches the arithmetic one.
  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  typedef enum logic [1:0] {
    K_LETTER,
    K_OPEN,
    K_CLOSE,
    K_OTHER
  } itp_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    itp_kind_t  kind;
    logic [1:0] prec;
    logic       eoe;
  } itp_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_FLUSH
  } itp_state_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = PREC_NONE;
    if (c == CH_POW) p = PREC_POW;
    else if (c == CH_MUL || c == CH_DIV) p = PREC_MUL;
    else if (c == CH_ADD || c == CH_SUB) p = PREC_ADD;
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

// ----- design/infix_to_postfix_converter_top.sv -----
// Top level of the infix-to-postfix converter: front end, queue and stack
// engine. Depends on itp_pkg, itp_front and itp_back.
//
// Characters go in one beat at a time; postfix characters and a done marker
// come out one beat each, with last set on the final beat caused by an input.
// The front end queues up to two classified characters. The stack engine
// finishes each character before it takes the next. Each operator popped off
// the stack is sent from the top register, which is then reloaded from the
// stack RAM's registered read port, and the final character also sends the
// done marker. A push onto a full stack of STACK_DEPTH entries drops the
// character and sets the overflow flag reported on the next done marker.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       end_of_expr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       is_char,
  output logic       overflow,
  output logic       last
);
  import itp_pkg::*;

  logic      q_valid;
  itp_item_t q_item;
  logic      q_take;

  itp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ch          (ch),
    .end_of_expr (end_of_expr),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .is_char   (is_char),
    .overflow  (overflow),
    .last      (last)
  );

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("queue read with no entry");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_char |-> last && out_char == 8'h00)
    else $error("done marker not last or carries a character");

  a_char_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_char |-> !overflow)
    else $error("overflow flag on a character beat");

endmodule

// ----- design/itp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/itp_front.sv -----
// Front end: accepts input beats, classifies each character and queues it
// for the stack engine in a two-entry FIFO. Depends on itp_pkg.
module itp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        ch,
  input  logic              end_of_expr,
  output logic              q_valid,
  output itp_pkg::itp_item_t q_item,
  input  logic              q_take
);
  import itp_pkg::*;

  itp_item_t  fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       push;
  itp_item_t  cls;

  always_comb begin
    cls.ch   = ch;
    cls.eoe  = end_of_expr;
    cls.prec = prec_of(ch);
    priority if (is_letter(ch)) cls.kind = K_LETTER;
    else if (ch == CH_OPEN) cls.kind = K_OPEN;
    else if (ch == CH_CLOSE) cls.kind = K_CLOSE;
    else cls.kind = K_OTHER;
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = fifo[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !q_take) cnt_next = cnt + 2'd1;
    else if (!push && q_take) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
    end
  end

endmodule

// ----- design/itp_back.sv -----
// Back end: operator stack engine and output register. Top of stack lives in
// a register, entries below it in itp_ram. Depends on itp_pkg and itp_ram.
module itp_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  itp_pkg::itp_item_t q_item,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               is_char,
  output logic               overflow,
  output logic               last
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  itp_state_t state, state_next;
  itp_item_t  cur;
  logic       char_done;
  logic       flushing;
  logic [CW-1:0] count;
  logic [7:0] top;
  logic       ovf_seen;

  // Held result: released with last=0 when another follows, last=1 at item end.
  logic       pend_valid;
  logic [7:0] pend_char;
  logic       pend_is_char;
  logic       pend_ovf;

  logic       out_free;
  logic       can_emit;
  logic       top_ge;
  logic       top_open;
  itp_state_t after_st;

  logic       do_emit;
  logic       emit_done;
  logic       emit_letter;
  logic       do_push;
  logic       do_pop;
  logic       set_done;
  logic       fin_move;
  logic       take;
  logic       out_load;
  logic [7:0] new_char;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign out_free = !out_valid || !out_stall;
  assign can_emit = !pend_valid || out_free;
  assign top_open = (top == CH_OPEN);
  assign top_ge   = (count != '0) && (cur.prec <= prec_of(top));
  assign after_st = cur.eoe ? S_FLUSH : S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (can_emit && q_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (char_done) begin
          state_next = after_st;
        end else begin
          unique case (cur.kind)
            K_LETTER: if (can_emit) state_next = after_st;
            K_OPEN:   state_next = after_st;
            K_CLOSE: begin
              priority if (count == '0) state_next = after_st;
              else if (top_open || can_emit) state_next = S_LOAD;
            end
            K_OTHER: begin
              if (!top_ge) state_next = after_st;
              else if (can_emit) state_next = S_LOAD;
            end
          endcase
        end
      end
      S_LOAD: state_next = flushing ? S_FLUSH : S_SCAN;
      S_FLUSH: begin
        if (can_emit) state_next = (count != '0) ? S_LOAD : S_IDLE;
      end
    endcase
  end

  always_comb begin
    do_emit     = 1'b0;
    emit_done   = 1'b0;
    emit_letter = 1'b0;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    set_done    = 1'b0;
    fin_move    = 1'b0;
    take        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (can_emit) begin
          fin_move = pend_valid;
          take     = q_valid;
        end
      end
      S_SCAN: begin
        if (!char_done) begin
          unique case (cur.kind)
            K_LETTER: begin
              if (can_emit) begin
                do_emit     = 1'b1;
                emit_letter = 1'b1;
              end
            end
            K_OPEN: do_push = 1'b1;
            K_CLOSE: begin
              if (count != '0) begin
                if (top_open) begin
                  do_pop   = 1'b1;
                  set_done = 1'b1;
                end else if (can_emit) begin
                  do_pop  = 1'b1;
                  do_emit = 1'b1;
                end
              end
            end
            K_OTHER: begin
              if (!top_ge) begin
                do_push = 1'b1;
              end else if (can_emit) begin
                do_pop  = 1'b1;
                do_emit = 1'b1;
              end
            end
          endcase
        end
      end
      S_LOAD: ;
      S_FLUSH: begin
        if (can_emit) begin
          do_emit = 1'b1;
          if (count != '0) do_pop = 1'b1;
          else emit_done = 1'b1;
        end
      end
    endcase
  end

  assign q_take   = take;
  assign new_char = emit_done ? 8'h00 : (emit_letter ? cur.ch : top);
  assign out_load = fin_move || (do_emit && pend_valid);

  assign ram_we    = do_push && (count != CW'(STACK_DEPTH)) && (count != '0);
  assign ram_waddr = AW'(count - CW'(1));
  assign ram_raddr = AW'(count - CW'(2));

  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (take) cur <= q_item;
    if (state == S_LOAD) top <= ram_rdata;
    if (do_push && count != CW'(STACK_DEPTH)) top <= cur.ch;
    if (do_emit) begin
      pend_char    <= new_char;
      pend_is_char <= !emit_done;
      pend_ovf     <= emit_done && ovf_seen;
    end
    if (out_load) begin
      out_char <= pend_char;
      is_char  <= pend_is_char;
      overflow <= pend_ovf;
      last     <= fin_move;
    end
    if (rst) begin
      state      <= S_IDLE;
      char_done  <= 1'b0;
      flushing   <= 1'b0;
      count      <= '0;
      ovf_seen   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        char_done <= 1'b0;
        flushing  <= 1'b0;
      end else begin
        if (set_done) char_done <= 1'b1;
        if (state == S_FLUSH) flushing <= 1'b1;
      end
      if (do_push) begin
        if (count == CW'(STACK_DEPTH)) ovf_seen <= 1'b1;
        else count <= count + CW'(1);
      end
      if (do_pop) count <= count - CW'(1);
      if (emit_done) ovf_seen <= 1'b0;
      if (do_emit) pend_valid <= 1'b1;
      else if (fin_move) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
